[rtl/core/bsc_pkg.sv]
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

  localparam int unsigned RawW     = 24;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ModelW   = 2;
  localparam int unsigned DtW      = 25;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgSens  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOff   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTcs   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTco   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTref  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTsens = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgModel = 3'd6;

  localparam logic [ModelW-1:0] ModelMaxOk = 2'd1;

  typedef struct packed {
    logic [RawW-1:0]       d1;
    logic signed [DtW-1:0] dt;
    logic                  ok;
  } item_t;

  typedef struct packed {
    logic [CoefW-1:0] sens;
    logic [CoefW-1:0] off;
    logic [CoefW-1:0] tcs;
    logic [CoefW-1:0] tco;
    logic [CoefW-1:0] tsens;
  } coef_t;

endpackage

[rtl/core/bsc_front.sv]
// Front stage: takes raw beats, forms dT and the model check.
module bsc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [bsc_pkg::RawW-1:0]    d1_i,
  input  logic [bsc_pkg::RawW-1:0]    d2_i,
  input  logic [bsc_pkg::CoefW-1:0]   tref_i,
  input  logic [bsc_pkg::ModelW-1:0]  model_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output bsc_pkg::item_t              item_o
);
  import bsc_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d.d1 = d1_i;
    item_d.dt = $signed({1'b0, d2_i}) - $signed({1'b0, tref_i, 8'd0});
    item_d.ok = (model_i <= ModelMaxOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end
endmodule

[rtl/core/bsc_queue.sv]
// Two-entry queue between front and back.
module bsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  bsc_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           empty_o,
  output bsc_pkg::item_t item_o
);
  import bsc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end
endmodule

[rtl/core/bsc_back.sv]
// Back pipeline: first- and second-order compensation, pressure product.
module bsc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  bsc_pkg::item_t             item_i,
  input  bsc_pkg::coef_t             coef_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [bsc_pkg::OutW-1:0]   pres_o,
  output logic [bsc_pkg::OutW-1:0]   temp_o,
  output logic                       ok_o
);
  import bsc_pkg::*;

  localparam int unsigned NStg = 8;

  logic [NStg-1:0] v_q;
  logic            adv;

  assign adv     = !v_q[NStg-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q[NStg-1];

  // stage 1
  logic [RawW-1:0] d1_1_q; logic ok1_q;
  logic signed [41:0] m1_q, m2_q, m3_q;
  logic signed [49:0] dsq_q;
  // stage 2
  logic [RawW-1:0] d1_2_q; logic ok2_q;
  logic signed [18:0] dd_2_q;
  logic signed [19:0] dl_2_q, temp0_2_q;
  logic signed [47:0] off_2_q, sens_2_q;
  logic [18:0] t2_2_q;
  logic low1_2_q, low2_2_q;
  // stage 3
  logic [RawW-1:0] d1_3_q; logic ok3_q;
  logic signed [19:0] temp0_3_q;
  logic signed [47:0] off_3_q, sens_3_q;
  logic [18:0] t2_3_q;
  logic low1_3_q, low2_3_q;
  logic [37:0] ddsq_3_q;
  logic [39:0] dlsq_3_q;
  // stage 4
  logic [RawW-1:0] d1_4_q; logic ok4_q;
  logic signed [47:0] off_4_q, sens_4_q;
  logic [47:0] off2_4_q, sens2_4_q;
  logic signed [31:0] temp_4_q;
  // stage 5
  logic [RawW-1:0] d1_5_q; logic ok5_q;
  logic signed [47:0] offf_5_q;
  logic signed [40:0] sensf_5_q;
  logic signed [31:0] temp_5_q;
  // stage 6
  logic ok6_q;
  logic signed [47:0] offf_6_q;
  logic signed [31:0] temp_6_q;
  logic [43:0] plo_6_q;
  logic signed [45:0] phi_6_q;
  // stage 7
  logic ok7_q;
  logic signed [47:0] offf_7_q;
  logic signed [31:0] temp_7_q;
  logic signed [44:0] q_7_q;
  // stage 8 (output)
  logic [OutW-1:0] pres_q, temp_q;
  logic ok_q;

  logic signed [16:0] c6s, c4s, c3s;
  logic signed [65:0] prod7;
  logic signed [48:0] diff8;

  assign c6s = $signed({1'b0, coef_i.tsens});
  assign c4s = $signed({1'b0, coef_i.tco});
  assign c3s = $signed({1'b0, coef_i.tcs});

  always_comb begin
    prod7 = ($signed({{20{phi_6_q[45]}}, phi_6_q}) <<< 20) + $signed({22'd0, plo_6_q});
    diff8 = $signed({{4{q_7_q[44]}}, q_7_q}) - $signed({offf_7_q[47], offf_7_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_1_q <= item_i.d1;
      ok1_q  <= item_i.ok;
      m1_q   <= 42'(item_i.dt * c6s);
      m2_q   <= 42'(item_i.dt * c4s);
      m3_q   <= 42'(item_i.dt * c3s);
      dsq_q  <= 50'(item_i.dt * item_i.dt);

      d1_2_q    <= d1_1_q;
      ok2_q     <= ok1_q;
      dd_2_q    <= m1_q[41:23];
      dl_2_q    <= $signed({m1_q[41], m1_q[41:23]}) + 20'sd3500;
      temp0_2_q <= $signed({m1_q[41], m1_q[41:23]}) + 20'sd2000;
      low1_2_q  <= m1_q[41];
      low2_2_q  <= ($signed(m1_q[41:23]) < -19'sd3500);
      t2_2_q    <= dsq_q[49:31];
      off_2_q   <= $signed({15'd0, coef_i.off, 17'd0})
                   + $signed({{12{m2_q[41]}}, m2_q[41:6]});
      sens_2_q  <= $signed({16'd0, coef_i.sens, 16'd0})
                   + $signed({{13{m3_q[41]}}, m3_q[41:7]});

      d1_3_q    <= d1_2_q;
      ok3_q     <= ok2_q;
      temp0_3_q <= temp0_2_q;
      off_3_q   <= off_2_q;
      sens_3_q  <= sens_2_q;
      t2_3_q    <= t2_2_q;
      low1_3_q  <= low1_2_q;
      low2_3_q  <= low2_2_q;
      ddsq_3_q  <= 38'(dd_2_q * dd_2_q);
      dlsq_3_q  <= 40'(dl_2_q * dl_2_q);

      d1_4_q   <= d1_3_q;
      ok4_q    <= ok3_q;
      off_4_q  <= off_3_q;
      sens_4_q <= sens_3_q;
      off2_4_q <= (low1_3_q ? (((48'(ddsq_3_q) << 6) - 48'(ddsq_3_q) - (48'(ddsq_3_q) << 1))
                   >> 4) : 48'd0)
                  + (low2_3_q ? ((48'(dlsq_3_q) << 4) - 48'(dlsq_3_q)) : 48'd0);
      sens2_4_q <= (low1_3_q ? (48'(ddsq_3_q) << 1) : 48'd0)
                   + (low2_3_q ? (48'(dlsq_3_q) << 3) : 48'd0);
      temp_4_q <= 32'($signed({{12{temp0_3_q[19]}}, temp0_3_q})
                  - (low1_3_q ? $signed({13'd0, t2_3_q}) : 32'sd0));

      d1_5_q    <= d1_4_q;
      ok5_q     <= ok4_q;
      offf_5_q  <= off_4_q - $signed(off2_4_q);
      sensf_5_q <= 41'(sens_4_q - $signed(sens2_4_q));
      temp_5_q  <= temp_4_q;

      ok6_q    <= ok5_q;
      offf_6_q <= offf_5_q;
      temp_6_q <= temp_5_q;
      plo_6_q  <= 44'(d1_5_q) * 44'(sensf_5_q[19:0]);
      phi_6_q  <= 46'($signed({1'b0, d1_5_q}) * $signed(sensf_5_q[40:20]));

      ok7_q    <= ok6_q;
      offf_7_q <= offf_6_q;
      temp_7_q <= temp_6_q;
      q_7_q    <= prod7[65:21];

      ok_q   <= ok7_q;
      pres_q <= ok7_q ? diff8[46:15] : '0;
      temp_q <= ok7_q ? temp_7_q : '0;
    end
  end

  assign pres_o = pres_q;
  assign temp_o = temp_q;
  assign ok_o   = ok_q;
endmodule

[rtl/core/baro_sensor_compensation.sv]
// Top level: barometric sensor compensation, config registers and stream ports.
//  channel   dir  content
//  s_axis    in   tdata[23:0] raw_pressure, [47:24] raw_temp
//  m_axis    out  tdata[31:0] pressure_pa, [63:32] temp_centi; tuser result_valid
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// One beat per cycle sustained while m_axis is not stalled; data passes the front register,
// the queue, and 8 back stages set by the multiplier chain (pressure product split into two halves).
// Reset clears control state and all coefficient registers.
// A stall at m_axis backs up the back pipe, then the queue, then s_axis.
module baro_sensor_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,   // raw_pressure, raw_temp
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [63:0]                       m_axis_tdata,   // pressure_pa, temp_centi
  output logic                              m_axis_tuser,   // result_valid
  input  logic                              cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bsc_pkg::CoefW-1:0]         cfg_data_i
);
  import bsc_pkg::*;

  coef_t            coef_q;
  logic [CoefW-1:0] tref_q;
  logic [ModelW-1:0] model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      tref_q  <= '0;
      model_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSens:  coef_q.sens  <= cfg_data_i;
        CfgOff:   coef_q.off   <= cfg_data_i;
        CfgTcs:   coef_q.tcs   <= cfg_data_i;
        CfgTco:   coef_q.tco   <= cfg_data_i;
        CfgTref:  tref_q       <= cfg_data_i;
        CfgTsens: coef_q.tsens <= cfg_data_i;
        CfgModel: model_q      <= cfg_data_i[ModelW-1:0];
        default: ;
      endcase
    end
  end

  logic  f_valid, q_full, q_empty, b_ready;
  item_t f_item, q_item;
  logic [OutW-1:0] pres, temp;

  bsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .d1_i    (s_axis_tdata[23:0]),
    .d2_i    (s_axis_tdata[47:24]),
    .tref_i  (tref_q),
    .model_i (model_q),
    .valid_o (f_valid),
    .ready_i (!q_full),
    .item_o  (f_item)
  );

  bsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .full_o  (q_full),
    .item_i  (f_item),
    .pop_i   (b_ready),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  bsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .ready_o (b_ready),
    .item_i  (q_item),
    .coef_i  (coef_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pres_o  (pres),
    .temp_o  (temp),
    .ok_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {temp, pres};
endmodule

[verif/tb_baro_sensor_compensation.sv]
// Testbench for the barometric compensation block: directed and random stream traffic checked by a predictor.
`timescale 1ns / 100ps

module tb_baro_sensor_compensation;
  import bsc_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] pressure_pa;
    logic [OutW-1:0] temp_centi;
    logic            result_valid;
  } comp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CoefW-1:0]    cfg_data_i = '0;

  logic [CoefW-1:0]    coef_shadow [7];
  logic [47:0]         raw_pending [$];
  comp_t               comp_expected [$];
  int                  err_cnt = 0;
  int                  quiet_cycles = 0;
  int                  in_gap = 0;
  int                  out_stall = 0;
  bit                  gaps_on = 1'b1;

  baro_sensor_compensation u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic comp_t compensate(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    comp_t  r;
    longint dt, temp, t2, off2, sens2, off, sens, p, dd, dlow;
    r = '0;
    if (coef_shadow[CfgModel][ModelW-1:0] > ModelMaxOk) return r;
    t2 = 0; off2 = 0; sens2 = 0;
    dt = longint'(d2) - (longint'(coef_shadow[CfgTref]) << 8);
    temp = 2000 + ((dt * longint'(coef_shadow[CfgTsens])) >>> 23);
    if (temp < 2000) begin
      dd = temp - 2000;
      t2 = (dt * dt) >>> 31;
      off2 = (61 * dd * dd) >>> 4;
      sens2 = 2 * dd * dd;
    end
    if (temp < -1500) begin
      dlow = temp + 1500;
      off2 += 15 * dlow * dlow;
      sens2 += 8 * dlow * dlow;
    end
    off = (longint'(coef_shadow[CfgOff]) << 17) + ((longint'(coef_shadow[CfgTco]) * dt) >>> 6);
    sens = (longint'(coef_shadow[CfgSens]) << 16) + ((longint'(coef_shadow[CfgTcs]) * dt) >>> 7);
    temp -= t2;
    off -= off2;
    sens -= sens2;
    p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    r.pressure_pa = p[31:0];
    r.temp_centi = temp[31:0];
    r.result_valid = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap();
    if (!gaps_on) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(40, 8);
    if ($urandom_range(2) == 0) return $urandom_range(3, 1);
    return 0;
  endfunction

  // stimulus driver
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (raw_pending.size() > 0) begin
        s_axis_tdata <= raw_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(posedge clk_i) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    comp_t got, want;
    bit    beat_seen;
    if (rst_ni) begin
      beat_seen = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        comp_expected.push_back(compensate(s_axis_tdata[23:0], s_axis_tdata[47:24]));
        beat_seen = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beat_seen = 1'b1;
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
        if (comp_expected.size() == 0) begin
          $error("unexpected beat: pressure_pa %0d", $signed(got.pressure_pa));
          err_cnt++;
        end else begin
          want = comp_expected.pop_front();
          if (got.pressure_pa !== want.pressure_pa) begin
            $error("pressure_pa exp %0d got %0d", $signed(want.pressure_pa),
                   $signed(got.pressure_pa));
            err_cnt++;
          end
          if (got.temp_centi !== want.temp_centi) begin
            $error("temp_centi exp %0d got %0d", $signed(want.temp_centi),
                   $signed(got.temp_centi));
            err_cnt++;
          end
          if (got.result_valid !== want.result_valid) begin
            $error("result_valid exp %0b got %0b", want.result_valid, got.result_valid);
            err_cnt++;
          end
        end
      end
      quiet_cycles <= beat_seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    coef_shadow[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (raw_pending.size() == 0 && !s_axis_tvalid && comp_expected.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic load_coefs(int kind);
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0: write_reg(i[CfgIdxW-1:0], '0);
        1: write_reg(i[CfgIdxW-1:0], '1);
        default: write_reg(i[CfgIdxW-1:0], CoefW'($urandom));
      endcase
    end
    write_reg(CfgModel, ($urandom_range(4) == 0) ? CoefW'($urandom_range(3, 2))
                                                 : CoefW'($urandom_range(1)));
  endtask

  initial begin
    logic [RawW-1:0] d2;
    for (int i = 0; i < 7; i++) coef_shadow[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // typical calibration set, directed readings
    write_reg(CfgSens, 16'd40127);
    write_reg(CfgOff, 16'd36924);
    write_reg(CfgTcs, 16'd23317);
    write_reg(CfgTco, 16'd23282);
    write_reg(CfgTref, 16'd33464);
    write_reg(CfgTsens, 16'd28312);
    write_reg(CfgModel, 16'd0);
    raw_pending.push_back({24'd8569150, 24'd9085466});
    raw_pending.push_back({24'd0, 24'd0});
    raw_pending.push_back({24'hFFFFFF, 24'hFFFFFF});
    raw_pending.push_back({24'd0, 24'hFFFFFF});
    raw_pending.push_back({24'hFFFFFF, 24'd0});
    raw_pending.push_back({24'd8200000, 24'd9085466});  // below 20 C
    raw_pending.push_back({24'd7000000, 24'd9085466});  // below -15 C
    raw_pending.push_back({24'd8566900, 24'hAAAAAA});
    raw_pending.push_back({24'd8567150, 24'h555555});
    drain();
    write_reg(CfgModel, 16'd1);
    raw_pending.push_back({24'd8569150, 24'd9085466});
    raw_pending.push_back({24'd6000000, 24'd1000});
    drain();
    for (int m = 2; m < 4; m++) begin
      write_reg(CfgModel, CoefW'(m));
      raw_pending.push_back({24'd8569150, 24'd9085466});
      raw_pending.push_back({24'hFFFFFF, 24'hFFFFFF});
      drain();
    end

    // random phases with varied calibration sets
    for (int ph = 0; ph < 12; ph++) begin
      load_coefs(ph == 1 ? 0 : (ph == 2 ? 1 : 2));
      gaps_on = (ph % 4 != 3);
      for (int n = 0; n < 128; n++) begin
        d2 = RawW'($urandom);
        if ($urandom_range(1) == 0)
          d2 = RawW'((int'(coef_shadow[CfgTref]) << 8) + $signed($urandom_range(8000000)) -
                     4000000);
        raw_pending.push_back({d2, RawW'($urandom)});
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
